FILE: hdl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants for the keyed record table
// Widths, status codes, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int C_CAPACITY = 64;

    localparam int ID_W    = 34;
    localparam int FEET_W  = 3;
    localparam int INCH_W  = 4;
    localparam int TOT_W   = 7;
    localparam int HGT_W   = 15;
    localparam int STAT_W  = 3;
    localparam int KEY_W   = TOT_W + ID_W;
    localparam int MEM_W   = TOT_W + INCH_W + FEET_W + ID_W;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    localparam logic [INCH_W-1:0] C_INCH_MAX          = INCH_W'(11);
    localparam logic [TOT_W-1:0]  C_INCH_PER_FOOT     = TOT_W'(12);
    localparam logic [HGT_W-1:0]  C_HUNDREDTHS_PER_IN = HGT_W'(254);

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_RECORD   = 3'd4,
        ST_NODATA   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHECK,
        S_UP_SCAN,
        S_UP_WAIT,
        S_UP_DECIDE,
        S_DUMP_START,
        S_SEL_START,
        S_SEL_SCAN,
        S_SEL_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    in_ld;
        logic    idx_clr;
        logic    rd_en;
        logic    wr_upd;
        logic    wr_ins;
        logic    emit_clr;
        logic    code_we;
        t_status code;
        logic    ld_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic range_bad;
        logic count_zero;
        logic full;
        logic hit;
        logic idx_last;
        logic emit_last;
        logic code_rec;
    } t_sts;

    function automatic logic [TOT_W-1:0] f_total(input logic [FEET_W-1:0] feet,
                                                 input logic [INCH_W-1:0] inch);
        f_total = TOT_W'(feet) * C_INCH_PER_FOOT + TOT_W'(inch);
    endfunction

endpackage

FILE: hdl/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl: sequencing state machine
// Steps an upsert through range check, key scan and write, and a dump
// through repeated minimum-selection passes, one record per pass.
// ----------------------------------------------------------------------------
module krt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    output logic          o_in_ready,
    input  krt_pkg::t_sts i_sts,
    output krt_pkg::t_cmd o_cmd
);

    krt_pkg::t_state r_state;
    krt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            krt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_op ? krt_pkg::S_DUMP_START : krt_pkg::S_UP_CHECK;
                end
            end
            krt_pkg::S_UP_CHECK: begin
                if (i_sts.range_bad) begin
                    n_state = krt_pkg::S_OUT;
                end else if (i_sts.count_zero) begin
                    n_state = krt_pkg::S_UP_DECIDE;
                end else begin
                    n_state = krt_pkg::S_UP_SCAN;
                end
            end
            krt_pkg::S_UP_SCAN: begin
                if (i_sts.idx_last) begin
                    n_state = krt_pkg::S_UP_WAIT;
                end
            end
            krt_pkg::S_UP_WAIT:   n_state = krt_pkg::S_UP_DECIDE;
            krt_pkg::S_UP_DECIDE: n_state = krt_pkg::S_OUT;
            krt_pkg::S_DUMP_START: begin
                n_state = i_sts.count_zero ? krt_pkg::S_OUT : krt_pkg::S_SEL_START;
            end
            krt_pkg::S_SEL_START: n_state = krt_pkg::S_SEL_SCAN;
            krt_pkg::S_SEL_SCAN: begin
                if (i_sts.idx_last) begin
                    n_state = krt_pkg::S_SEL_WAIT;
                end
            end
            krt_pkg::S_SEL_WAIT: n_state = krt_pkg::S_OUT;
            krt_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    if (i_sts.code_rec && !i_sts.emit_last) begin
                        n_state = krt_pkg::S_SEL_START;
                    end else begin
                        n_state = krt_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = krt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.code = krt_pkg::ST_INSERTED;
        o_in_ready = 1'b0;
        unique case (r_state)
            krt_pkg::S_IDLE: begin
                o_in_ready  = i_rst_n;
                o_cmd.in_ld = i_in_valid;
            end
            krt_pkg::S_UP_CHECK: begin
                o_cmd.idx_clr = 1'b1;
                if (i_sts.range_bad) begin
                    o_cmd.code_we = 1'b1;
                    o_cmd.code    = krt_pkg::ST_RANGE;
                end
            end
            krt_pkg::S_UP_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            krt_pkg::S_UP_WAIT: begin
                o_cmd.rd_en = 1'b0;
            end
            krt_pkg::S_UP_DECIDE: begin
                o_cmd.code_we = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.wr_upd = 1'b1;
                    o_cmd.code   = krt_pkg::ST_UPDATED;
                end else if (i_sts.full) begin
                    o_cmd.code   = krt_pkg::ST_FULL;
                end else begin
                    o_cmd.wr_ins = 1'b1;
                    o_cmd.code   = krt_pkg::ST_INSERTED;
                end
            end
            krt_pkg::S_DUMP_START: begin
                o_cmd.emit_clr = 1'b1;
                if (i_sts.count_zero) begin
                    o_cmd.code_we = 1'b1;
                    o_cmd.code    = krt_pkg::ST_NODATA;
                end
            end
            krt_pkg::S_SEL_START: begin
                o_cmd.idx_clr = 1'b1;
            end
            krt_pkg::S_SEL_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            krt_pkg::S_SEL_WAIT: begin
                o_cmd.code_we = 1'b1;
                o_cmd.code    = krt_pkg::ST_RECORD;
            end
            krt_pkg::S_OUT: begin
                o_cmd.ld_out = i_sts.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

FILE: hdl/krt_dpath.sv
// ----------------------------------------------------------------------------
// krt_dpath: record store, scan compare and result register
// Holds the record memory, the entry count, the scan index, the key match
// and minimum-selection logic, and the registered output transaction.
// ----------------------------------------------------------------------------
module krt_dpath #(
    parameter int CAPACITY = krt_pkg::C_CAPACITY
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  krt_pkg::t_cmd                    i_cmd,
    output krt_pkg::t_sts                    o_sts,
    input  logic [krt_pkg::ID_W-1:0]         i_in_id,
    input  logic [krt_pkg::FEET_W-1:0]       i_in_feet,
    input  logic [krt_pkg::INCH_W-1:0]       i_in_inch,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [krt_pkg::STAT_W-1:0]       o_out_status,
    output logic [krt_pkg::ID_W-1:0]         o_out_id,
    output logic [krt_pkg::FEET_W-1:0]       o_out_feet,
    output logic [krt_pkg::INCH_W-1:0]       o_out_inch,
    output logic [krt_pkg::HGT_W-1:0]        o_out_height,
    output logic                             o_out_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [krt_pkg::MEM_W-1:0]  r_mem [CAPACITY];
    logic [krt_pkg::MEM_W-1:0]  r_rd_data;
    logic [AW-1:0]              r_rd_addr;
    logic                       r_rd_vld;
    logic [AW-1:0]              r_idx;
    logic [CW-1:0]              r_count;
    logic [AW-1:0]              r_emit;

    logic [krt_pkg::ID_W-1:0]   r_in_id;
    logic [krt_pkg::FEET_W-1:0] r_in_feet;
    logic [krt_pkg::INCH_W-1:0] r_in_inch;

    logic                       r_hit;
    logic [AW-1:0]              r_hit_addr;
    logic                       r_found;
    logic                       r_have_prev;
    logic [krt_pkg::KEY_W-1:0]  r_min_key;
    logic [krt_pkg::FEET_W-1:0] r_min_feet;
    logic [krt_pkg::INCH_W-1:0] r_min_inch;
    logic [krt_pkg::KEY_W-1:0]  r_prev_key;
    krt_pkg::t_status           r_code;

    logic                       r_out_valid;
    logic [krt_pkg::STAT_W-1:0] r_out_status;
    logic [krt_pkg::ID_W-1:0]   r_out_id;
    logic [krt_pkg::FEET_W-1:0] r_out_feet;
    logic [krt_pkg::INCH_W-1:0] r_out_inch;
    logic [krt_pkg::HGT_W-1:0]  r_out_height;
    logic                       r_out_last;

    logic [CW-1:0]              n_count_m1;
    logic                       n_wr_en;
    logic [AW-1:0]              n_wr_addr;
    logic [krt_pkg::MEM_W-1:0]  n_wr_data;
    logic [krt_pkg::ID_W-1:0]   n_rd_id;
    logic [krt_pkg::FEET_W-1:0] n_rd_feet;
    logic [krt_pkg::INCH_W-1:0] n_rd_inch;
    logic [krt_pkg::TOT_W-1:0]  n_rd_tot;
    logic [krt_pkg::KEY_W-1:0]  n_rd_key;
    logic                       n_cand;
    logic [krt_pkg::ID_W-1:0]   n_out_id;
    logic [krt_pkg::FEET_W-1:0] n_out_feet;
    logic [krt_pkg::INCH_W-1:0] n_out_inch;
    logic                       n_out_last;
    logic                       n_out_free;

    assign n_count_m1 = r_count - CW'(1);
    assign n_out_free = !r_out_valid || i_out_ready;

    assign {n_rd_tot, n_rd_inch, n_rd_feet, n_rd_id} = r_rd_data;
    assign n_rd_key = {n_rd_tot, n_rd_id};
    assign n_cand   = !r_have_prev || (n_rd_key > r_prev_key);

    assign n_wr_en   = i_cmd.wr_upd || i_cmd.wr_ins;
    assign n_wr_addr = i_cmd.wr_upd ? r_hit_addr : r_count[AW-1:0];
    assign n_wr_data = {krt_pkg::f_total(r_in_feet, r_in_inch), r_in_inch, r_in_feet, r_in_id};

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ld) begin
            r_in_id   <= i_in_id;
            r_in_feet <= i_in_feet;
            r_in_inch <= i_in_inch;
        end
        if (i_cmd.rd_en) begin
            r_rd_addr <= r_idx;
        end
        if (r_rd_vld && (n_rd_id == r_in_id)) begin
            r_hit_addr <= r_rd_addr;
        end
        if (r_rd_vld && n_cand && (!r_found || (n_rd_key < r_min_key))) begin
            r_min_key  <= n_rd_key;
            r_min_feet <= n_rd_feet;
            r_min_inch <= n_rd_inch;
        end
        if (i_cmd.ld_out && (r_code == krt_pkg::ST_RECORD)) begin
            r_prev_key <= r_min_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_found     <= 1'b0;
            r_have_prev <= 1'b0;
            r_emit      <= '0;
            r_code      <= krt_pkg::ST_INSERTED;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.wr_ins) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_hit   <= 1'b0;
                r_found <= 1'b0;
            end else if (r_rd_vld) begin
                if (n_rd_id == r_in_id) begin
                    r_hit <= 1'b1;
                end
                if (n_cand) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.emit_clr) begin
                r_emit      <= '0;
                r_have_prev <= 1'b0;
            end else if (i_cmd.ld_out && (r_code == krt_pkg::ST_RECORD)) begin
                r_emit      <= r_emit + AW'(1);
                r_have_prev <= 1'b1;
            end
            if (i_cmd.code_we) begin
                r_code <= i_cmd.code;
            end
        end
    end

    always_comb begin
        n_out_id   = r_in_id;
        n_out_feet = r_in_feet;
        n_out_inch = r_in_inch;
        n_out_last = 1'b1;
        unique case (r_code) inside
            krt_pkg::ST_INSERTED, krt_pkg::ST_UPDATED: begin
                n_out_id = r_in_id;
            end
            krt_pkg::ST_FULL, krt_pkg::ST_RANGE: begin
                n_out_feet = '0;
                n_out_inch = '0;
            end
            krt_pkg::ST_RECORD: begin
                n_out_id   = r_min_key[krt_pkg::ID_W-1:0];
                n_out_feet = r_min_feet;
                n_out_inch = r_min_inch;
                n_out_last = (r_emit == n_count_m1[AW-1:0]);
            end
            default: begin
                n_out_id   = '0;
                n_out_feet = '0;
                n_out_inch = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_status <= r_code;
            r_out_id     <= n_out_id;
            r_out_feet   <= n_out_feet;
            r_out_inch   <= n_out_inch;
            r_out_height <= krt_pkg::HGT_W'(krt_pkg::f_total(n_out_feet, n_out_inch))
                            * krt_pkg::C_HUNDREDTHS_PER_IN;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_id     = r_out_id;
    assign o_out_feet   = r_out_feet;
    assign o_out_inch   = r_out_inch;
    assign o_out_height = r_out_height;
    assign o_out_last   = r_out_last;

    assign o_sts.out_free   = n_out_free;
    assign o_sts.range_bad  = (r_in_inch > krt_pkg::C_INCH_MAX);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.full       = (r_count == CW'(CAPACITY));
    assign o_sts.hit        = r_hit;
    assign o_sts.idx_last   = (r_idx == n_count_m1[AW-1:0]);
    assign o_sts.emit_last  = (r_emit == n_count_m1[AW-1:0]);
    assign o_sts.code_rec   = (r_code == krt_pkg::ST_RECORD);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("Entry count exceeds the table capacity.");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_ins |-> (r_count < CW'(CAPACITY)))
        else $error("Insert issued on a full table.");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("Insert did not advance the entry count.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_out |-> n_out_free)
        else $error("Result loaded over a transaction not yet taken.");

    a_rec_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ld_out && (r_code == krt_pkg::ST_RECORD)) |-> r_found)
        else $error("Record emitted without a selected entry.");
`endif

endmodule

FILE: hdl/keyed_record_table_sorted_dump_top.sv
// ----------------------------------------------------------------------------
// keyed_record_table_sorted_dump_top: keyed height table with sorted dump
// Upserts records keyed by a ten-digit identifier and dumps them sorted.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one command per transaction: tuser 0 upserts the
// record in tdata, tuser 1 dumps the table. The block takes a command only
// when it is idle, so one command is worked on at a time.
// An upsert gives one result transaction with tlast high. It scans the N
// stored keys one per cycle through the single memory read port, unless
// its inches are out of range.
// A dump emits the records ascending by height, then identifier, with tlast
// on the final one; an empty table gives a single no-data result. Each
// record is found by one selection pass over the memory.
// Results sit in an output register; while the receiver stalls the block
// holds that transaction and waits before loading the next one.
// Reset empties the table at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module keyed_record_table_sorted_dump_top #(
    parameter int CAPACITY = krt_pkg::C_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // record_id[33:0], feet[36:34], inches[40:37], zero fill[47:41]
    input  logic [krt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_id[33:0], out_feet[36:34], out_inches[40:37],
    // height_hundredths_cm[55:41]
    output logic [krt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // status[2:0]
    output logic [krt_pkg::STAT_W-1:0]          m_axis_tuser,
    output logic                                m_axis_tlast
);

    krt_pkg::t_cmd              w_cmd;
    krt_pkg::t_sts              w_sts;
    logic [krt_pkg::ID_W-1:0]   w_out_id;
    logic [krt_pkg::FEET_W-1:0] w_out_feet;
    logic [krt_pkg::INCH_W-1:0] w_out_inch;
    logic [krt_pkg::HGT_W-1:0]  w_out_height;

    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    krt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_id      (s_axis_tdata[33:0]),
        .i_in_feet    (s_axis_tdata[36:34]),
        .i_in_inch    (s_axis_tdata[40:37]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (m_axis_tuser),
        .o_out_id     (w_out_id),
        .o_out_feet   (w_out_feet),
        .o_out_inch   (w_out_inch),
        .o_out_height (w_out_height),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {w_out_height, w_out_inch, w_out_feet, w_out_id};

endmodule

FILE: tb/keyed_record_table_sorted_dump_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_sorted_dump_top_tb: self-checking bench for the table
// Drives upsert and dump commands over the slave stream and tracks the
// table in a scoreboard that predicts every result transaction. It starts
// with directed commands for the empty dump, the extreme identifiers and
// heights, the inch range check, updates and height ties. Random commands
// follow that fill the table to capacity, with the sender and the receiver
// stalling at random in the first two of three phases.
// ----------------------------------------------------------------------------
module keyed_record_table_sorted_dump_top_tb;

    localparam logic OP_UPSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;
    localparam logic [krt_pkg::ID_W-1:0] ID_MAX = krt_pkg::ID_W'(64'd9999999999);
    localparam logic [krt_pkg::ID_W-1:0] ID_LOW_ONES = krt_pkg::ID_W'(64'd8589934591);
    localparam logic [krt_pkg::ID_W-1:0] ID_TOP_BIT = krt_pkg::ID_W'(64'd8589934592);

    typedef struct {
        krt_pkg::t_status           status;
        logic [krt_pkg::ID_W-1:0]   id;
        logic [krt_pkg::FEET_W-1:0] feet;
        logic [krt_pkg::INCH_W-1:0] inch;
        logic [krt_pkg::HGT_W-1:0]  hgt;
        logic                       last;
    } t_table_result;

    class record_table_tracker;
        logic [krt_pkg::ID_W-1:0]   ids  [krt_pkg::C_CAPACITY];
        logic [krt_pkg::FEET_W-1:0] feet [krt_pkg::C_CAPACITY];
        logic [krt_pkg::INCH_W-1:0] inch [krt_pkg::C_CAPACITY];
        int                         stored;
        t_table_result              pending_results[$];
        int                         error_count;
        int                         printed;

        function new();
            stored      = 0;
            error_count = 0;
            printed     = 0;
        endfunction

        task report_mismatch(input string msg);
            error_count++;
            if (printed < 200) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
                printed++;
            end
        endtask

        function int total_of(input int i);
            return int'(feet[i]) * 12 + int'(inch[i]);
        endfunction

        function bit ranks_below(input int a, input int b);
            if (total_of(a) != total_of(b))
                return total_of(a) < total_of(b);
            return ids[a] < ids[b];
        endfunction

        function bit holds(input logic [krt_pkg::ID_W-1:0] id);
            for (int i = 0; i < stored; i++)
                if (ids[i] == id)
                    return 1'b1;
            return 1'b0;
        endfunction

        function logic [krt_pkg::ID_W-1:0] pick_stored();
            return ids[$urandom_range(stored - 1)];
        endfunction

        function void push_result(input krt_pkg::t_status st,
                                  input logic [krt_pkg::ID_W-1:0] id,
                                  input logic [krt_pkg::FEET_W-1:0] ft,
                                  input logic [krt_pkg::INCH_W-1:0] ic,
                                  input logic last);
            t_table_result r;
            r.status = st;
            r.id     = id;
            r.feet   = ft;
            r.inch   = ic;
            r.hgt    = krt_pkg::HGT_W'((int'(ft) * 12 + int'(ic)) * 254);
            r.last   = last;
            pending_results.push_back(r);
        endfunction

        function void sort_by_height();
            logic [krt_pkg::ID_W-1:0]   tid;
            logic [krt_pkg::FEET_W-1:0] tft;
            logic [krt_pkg::INCH_W-1:0] tic;
            int                         j;
            for (int i = 1; i < stored; i++) begin
                j = i;
                while (j > 0 && ranks_below(j, j - 1)) begin
                    tid = ids[j];
                    tft = feet[j];
                    tic = inch[j];
                    ids[j]      = ids[j - 1];
                    feet[j]     = feet[j - 1];
                    inch[j]     = inch[j - 1];
                    ids[j - 1]  = tid;
                    feet[j - 1] = tft;
                    inch[j - 1] = tic;
                    j--;
                end
            end
        endfunction

        function void apply_command(input logic op, input logic [krt_pkg::ID_W-1:0] id,
                                    input logic [krt_pkg::FEET_W-1:0] ft,
                                    input logic [krt_pkg::INCH_W-1:0] ic);
            int hit;
            hit = -1;
            if (op == OP_UPSERT) begin
                if (ic > krt_pkg::C_INCH_MAX) begin
                    push_result(krt_pkg::ST_RANGE, id, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < stored && hit < 0; i++)
                        if (ids[i] == id)
                            hit = i;
                    if (hit >= 0) begin
                        feet[hit] = ft;
                        inch[hit] = ic;
                        push_result(krt_pkg::ST_UPDATED, id, ft, ic, 1'b1);
                    end else if (stored >= krt_pkg::C_CAPACITY) begin
                        push_result(krt_pkg::ST_FULL, id, '0, '0, 1'b1);
                    end else begin
                        ids[stored]  = id;
                        feet[stored] = ft;
                        inch[stored] = ic;
                        stored++;
                        push_result(krt_pkg::ST_INSERTED, id, ft, ic, 1'b1);
                    end
                end
            end else if (stored == 0) begin
                push_result(krt_pkg::ST_NODATA, '0, '0, '0, 1'b1);
            end else begin
                sort_by_height();
                for (int i = 0; i < stored; i++)
                    push_result(krt_pkg::ST_RECORD, ids[i], feet[i], inch[i],
                                i == stored - 1);
            end
        endfunction

        task check_result(input logic [krt_pkg::STAT_W-1:0] st,
                          input logic [krt_pkg::ID_W-1:0] id,
                          input logic [krt_pkg::FEET_W-1:0] ft,
                          input logic [krt_pkg::INCH_W-1:0] ic,
                          input logic [krt_pkg::HGT_W-1:0] hgt, input logic last);
            t_table_result w;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d id %0d", st, id));
            end else begin
                w = pending_results.pop_front();
                if (st !== w.status || id !== w.id || ft !== w.feet || ic !== w.inch ||
                    hgt !== w.hgt || last !== w.last)
                    report_mismatch($sformatf(
                        {"got st %0d id %0d ft %0d in %0d h %0d last %0b, ",
                         "want %0d %0d %0d %0d %0d %0b"},
                        st, id, ft, ic, hgt, last,
                        w.status, w.id, w.feet, w.inch, w.hgt, w.last));
            end
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [krt_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [0:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [krt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [krt_pkg::STAT_W-1:0]      m_axis_tuser;
    logic                            m_axis_tlast;

    record_table_tracker sb;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    keyed_record_table_sorted_dump_top #(
        .CAPACITY(krt_pkg::C_CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[33:0], m_axis_tdata[36:34],
                            m_axis_tdata[40:37], m_axis_tdata[55:41], m_axis_tlast);
    end

    task automatic send_command(input logic op, input logic [krt_pkg::ID_W-1:0] id,
                                input logic [krt_pkg::FEET_W-1:0] ft,
                                input logic [krt_pkg::INCH_W-1:0] ic);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'b0, ic, ft, id};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.apply_command(op, id, ft, ic);
        @(negedge i_clk);
    endtask

    function automatic logic [krt_pkg::ID_W-1:0] random_id();
        case ($urandom_range(39))
            0: return '0;
            1: return ID_MAX;
            2: return ID_LOW_ONES;
            3: return ID_TOP_BIT;
            default: return krt_pkg::ID_W'({$urandom, $urandom} % 64'd10000000000);
        endcase
    endfunction

    function automatic logic [krt_pkg::ID_W-1:0] fresh_id();
        logic [krt_pkg::ID_W-1:0] id;
        id = random_id();
        while (sb.holds(id))
            id = random_id();
        return id;
    endfunction

    task automatic random_command();
        int dump_pct;
        int pick;
        dump_pct = (sb.stored < 20) ? 15 : 3;
        pick = $urandom_range(99);
        if (pick < dump_pct) begin
            send_command(OP_DUMP, krt_pkg::ID_W'({$urandom, $urandom}),
                         krt_pkg::FEET_W'($urandom), krt_pkg::INCH_W'($urandom));
        end else begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_command(OP_UPSERT, (sb.stored > 0 && pick < 4) ? sb.pick_stored()
                             : fresh_id(), krt_pkg::FEET_W'($urandom),
                             krt_pkg::INCH_W'($urandom_range(15, 12)));
            else if (pick < 45 && sb.stored > 0)
                send_command(OP_UPSERT, sb.pick_stored(), krt_pkg::FEET_W'($urandom),
                             krt_pkg::INCH_W'($urandom_range(11)));
            else
                send_command(OP_UPSERT, fresh_id(), krt_pkg::FEET_W'($urandom),
                             krt_pkg::INCH_W'($urandom_range(11)));
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct = 14;
        recv_idle_pct = 60;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_command(OP_DUMP, ID_LOW_ONES, 3'd7, 4'd15);
        send_command(OP_UPSERT, ID_MAX, 3'd7, 4'd11);
        send_command(OP_UPSERT, '0, 3'd0, 4'd0);
        send_command(OP_UPSERT, ID_LOW_ONES, 3'd5, 4'd6);
        send_command(OP_UPSERT, krt_pkg::ID_W'(64'd1234567890), 3'd5, 4'd6);
        send_command(OP_UPSERT, '0, 3'd7, 4'd12);
        send_command(OP_UPSERT, krt_pkg::ID_W'(64'd55), 3'd3, 4'd15);
        send_command(OP_UPSERT, krt_pkg::ID_W'(64'd4242), 3'd2, 4'd13);
        send_command(OP_UPSERT, krt_pkg::ID_W'(64'd4242), 3'd2, 4'd14);
        send_command(OP_DUMP, '0, 3'd0, 4'd0);
        send_command(OP_UPSERT, '0, 3'd6, 4'd11);
        send_command(OP_UPSERT, ID_MAX, 3'd0, 4'd1);
        send_command(OP_UPSERT, ID_TOP_BIT, 3'd1, 4'd10);
        send_command(OP_DUMP, ID_MAX, 3'd2, 4'd5);

        repeat (51) random_command();
        send_idle_pct = 60;
        recv_idle_pct = 14;
        repeat (51) random_command();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (51) random_command();

        while (sb.stored < krt_pkg::C_CAPACITY)
            send_command(OP_UPSERT, fresh_id(), krt_pkg::FEET_W'($urandom),
                         krt_pkg::INCH_W'($urandom_range(11)));
        send_command(OP_UPSERT, fresh_id(), 3'd4, 4'd4);
        send_command(OP_UPSERT, sb.pick_stored(), 3'd7, 4'd11);
        send_command(OP_DUMP, '0, 3'd0, 4'd0);
        s_axis_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
